// ----- design/cascaded_shelf_biquad_filter_unit_macros.svh -----
// Assertion macros for the cascaded shelf biquad filter unit.
// Used by the port checker; depends on nothing.
`ifndef CASCADED_SHELF_BIQUAD_FILTER_UNIT_MACROS_SVH
`define CASCADED_SHELF_BIQUAD_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CSBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CSBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/csbf_pkg.sv -----
// Shared types, constants and microcode for the cascaded shelf biquad filter.
// No dependencies; used by the sequencer, datapath and top level.
package csbf_pkg;

  localparam int COEF_BITS      = 32;
  localparam int CFG_BITS       = 64;
  localparam int CFG_IDX_BITS   = 3;
  localparam int COEF_NUM       = 5;
  localparam int STATE_BITS     = 44;
  localparam int STATE_FRAC     = 39;
  localparam int TERM_LIMIT_EXP = 60;
  localparam int STEP_BITS      = 4;

  localparam logic [STEP_BITS-1:0] STEP_HOME = '0;

  localparam logic [COEF_NUM-1:0][CFG_BITS-1:0] COEF_RESET = {
    64'h0, 64'h0, 64'h0, 64'h0, 64'h1000_0000_1000_0000
  };

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_B0_PAIR = 3'd0,
    REG_B1_PAIR = 3'd1,
    REG_B2_PAIR = 3'd2,
    REG_A1_PAIR = 3'd3,
    REG_A2_PAIR = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT,
    JMP_HOME
  } jmp_t;

  typedef enum logic {
    STAGE_HIGH,
    STAGE_LOW
  } stage_t;

  typedef enum logic {
    OPND_IN,
    OPND_Y
  } opnd_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_A_T_D1,
    ACC_A_T_D2,
    ACC_B_T,
    ACC_D1_WB,
    ACC_D2_WB
  } acc_op_t;

  typedef struct packed {
    jmp_t     jmp;
    logic     mul_en;
    stage_t   mul_stage;
    cfg_reg_t coef;
    opnd_t    opnd;
    acc_op_t  acc_op;
    stage_t   acc_stage;
    logic     y_ld;
    logic     out_ld;
  } ctrl_t;

  function automatic ctrl_t uop(input jmp_t jmp, input logic mul_en, input stage_t mul_stage,
                                input cfg_reg_t coef, input opnd_t opnd, input acc_op_t acc_op,
                                input stage_t acc_stage, input logic y_ld, input logic out_ld);
    return '{jmp, mul_en, mul_stage, coef, opnd, acc_op, acc_stage, y_ld, out_ld};
  endfunction

  // one control word per step; each product is registered in prod_r before the step that uses it
  function automatic ctrl_t ucode_rom(input logic [STEP_BITS-1:0] step);
    case (step)
      4'd0:  return uop(JMP_WAIT_IN,  1'b0, STAGE_HIGH, REG_B0_PAIR, OPND_IN, ACC_NOP,
                        STAGE_HIGH, 1'b0, 1'b0);
      4'd1:  return uop(JMP_NEXT, 1'b1, STAGE_HIGH, REG_B0_PAIR, OPND_IN, ACC_NOP,
                        STAGE_HIGH, 1'b0, 1'b0);
      4'd2:  return uop(JMP_NEXT, 1'b1, STAGE_HIGH, REG_B1_PAIR, OPND_IN, ACC_A_T_D1,
                        STAGE_HIGH, 1'b0, 1'b0);
      4'd3:  return uop(JMP_NEXT, 1'b1, STAGE_HIGH, REG_B2_PAIR, OPND_IN, ACC_A_T_D2,
                        STAGE_HIGH, 1'b1, 1'b0);
      4'd4:  return uop(JMP_NEXT, 1'b1, STAGE_HIGH, REG_A1_PAIR, OPND_Y, ACC_B_T,
                        STAGE_HIGH, 1'b0, 1'b0);
      4'd5:  return uop(JMP_NEXT, 1'b1, STAGE_HIGH, REG_A2_PAIR, OPND_Y, ACC_D1_WB,
                        STAGE_HIGH, 1'b0, 1'b0);
      4'd6:  return uop(JMP_NEXT, 1'b1, STAGE_LOW, REG_B0_PAIR, OPND_Y, ACC_D2_WB,
                        STAGE_HIGH, 1'b0, 1'b0);
      4'd7:  return uop(JMP_NEXT, 1'b1, STAGE_LOW, REG_B1_PAIR, OPND_Y, ACC_A_T_D1,
                        STAGE_LOW, 1'b0, 1'b0);
      4'd8:  return uop(JMP_NEXT, 1'b1, STAGE_LOW, REG_B2_PAIR, OPND_Y, ACC_A_T_D2,
                        STAGE_LOW, 1'b1, 1'b0);
      4'd9:  return uop(JMP_NEXT, 1'b1, STAGE_LOW, REG_A1_PAIR, OPND_Y, ACC_B_T,
                        STAGE_LOW, 1'b0, 1'b0);
      4'd10: return uop(JMP_NEXT, 1'b1, STAGE_LOW, REG_A2_PAIR, OPND_Y, ACC_D1_WB,
                        STAGE_LOW, 1'b0, 1'b0);
      4'd11: return uop(JMP_NEXT, 1'b0, STAGE_LOW, REG_B0_PAIR, OPND_Y, ACC_D2_WB,
                        STAGE_LOW, 1'b0, 1'b0);
      4'd12: return uop(JMP_WAIT_OUT, 1'b0, STAGE_LOW, REG_B0_PAIR, OPND_Y, ACC_NOP,
                        STAGE_LOW, 1'b0, 1'b1);
      default: return uop(JMP_HOME, 1'b0, STAGE_HIGH, REG_B0_PAIR, OPND_IN, ACC_NOP,
                          STAGE_HIGH, 1'b0, 1'b0);
    endcase
  endfunction

endpackage

// ----- design/csbf_sequencer.sv -----
// Step counter and microcode table readout for the biquad cascade.
// Depends on csbf_pkg.
module csbf_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  output csbf_pkg::ctrl_t     ctrl,
  output logic                in_take
);

  logic [csbf_pkg::STEP_BITS-1:0] step_r;
  logic [csbf_pkg::STEP_BITS-1:0] step_nxt;

  assign ctrl    = csbf_pkg::ucode_rom(step_r);
  assign in_take = (ctrl.jmp == csbf_pkg::JMP_WAIT_IN);

  always_comb begin
    case (ctrl.jmp)
      csbf_pkg::JMP_NEXT:     step_nxt = csbf_pkg::STEP_BITS'(step_r + 1'b1);
      csbf_pkg::JMP_WAIT_IN:  step_nxt = in_valid ? csbf_pkg::STEP_BITS'(step_r + 1'b1)
                                                  : step_r;
      csbf_pkg::JMP_WAIT_OUT: step_nxt = out_free ? csbf_pkg::STEP_HOME : step_r;
      default:                step_nxt = csbf_pkg::STEP_HOME;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= csbf_pkg::STEP_HOME;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- design/csbf_datapath.sv -----
// Shared multiplier, term alignment, two accumulators and delay state.
// Depends on csbf_pkg; driven by the control word of csbf_sequencer.
module csbf_datapath #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  csbf_pkg::ctrl_t                                    ctrl,
  input  logic [csbf_pkg::COEF_NUM-1:0][csbf_pkg::CFG_BITS-1:0] coef_bank,
  input  logic signed [SAMPLE_BITS-1:0]                      x_in,
  output logic signed [SAMPLE_BITS-1:0]                      y_out
);

  localparam int PROD_W     = csbf_pkg::COEF_BITS + SAMPLE_BITS;
  localparam int WIDE_W     = PROD_W + 16;
  localparam int TERM_SHIFT = SAMPLE_BITS - 1 + COEF_FRAC_BITS - csbf_pkg::STATE_FRAC;
  localparam int RSH        = (TERM_SHIFT > 0) ? TERM_SHIFT : 0;
  localparam int LSH        = (TERM_SHIFT < 0) ? -TERM_SHIFT : 0;
  localparam int TERM_W     = csbf_pkg::TERM_LIMIT_EXP + 2;
  localparam int ACC_W      = TERM_W + 1;
  localparam int OUT_SHIFT  = csbf_pkg::STATE_FRAC - (SAMPLE_BITS - 1);

  localparam logic signed [WIDE_W-1:0] TERM_HALF = (WIDE_W'(1) << RSH) >> 1;
  localparam logic signed [WIDE_W-1:0] TERM_MAX  = WIDE_W'(1) << csbf_pkg::TERM_LIMIT_EXP;
  localparam logic signed [WIDE_W-1:0] TERM_MIN  = -TERM_MAX;
  localparam logic signed [ACC_W-1:0]  Y_HALF    = ACC_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]  Y_MAX     = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0]  Y_MIN     = -(ACC_W'(1) << (SAMPLE_BITS - 1));
  localparam logic signed [ACC_W-1:0]  ST_MAX    =
    (ACC_W'(1) << (csbf_pkg::STATE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0]  ST_MIN    =
    -(ACC_W'(1) << (csbf_pkg::STATE_BITS - 1));

  logic [csbf_pkg::CFG_BITS-1:0]             pair_w;
  logic signed [csbf_pkg::COEF_BITS-1:0]     coef_w;
  logic signed [SAMPLE_BITS-1:0]             opnd_w;
  logic signed [PROD_W-1:0]                  prod_nxt;
  logic signed [PROD_W-1:0]                  prod_r;
  logic signed [WIDE_W-1:0]                  wide_w;
  logic signed [WIDE_W-1:0]                  shifted_w;
  logic signed [TERM_W-1:0]                  term_w;
  logic signed [ACC_W-1:0]                   acc_a_r;
  logic signed [ACC_W-1:0]                   acc_a_nxt;
  logic signed [ACC_W-1:0]                   acc_b_r;
  logic signed [ACC_W-1:0]                   acc_b_nxt;
  logic signed [ACC_W-1:0]                   yr_w;
  logic signed [SAMPLE_BITS-1:0]             y_sat_w;
  logic signed [SAMPLE_BITS-1:0]             y_r;
  logic signed [ACC_W-1:0]                   wb_w;
  logic signed [csbf_pkg::STATE_BITS-1:0]    wb_sat_w;
  logic signed [csbf_pkg::STATE_BITS-1:0]    d_sel_w;
  logic signed [csbf_pkg::STATE_BITS-1:0]    d1_r [2];
  logic signed [csbf_pkg::STATE_BITS-1:0]    d2_r [2];

  // coefficient pick: low half feeds the high shelf, upper half the low shelf
  always_comb begin
    case (ctrl.coef)
      csbf_pkg::REG_B0_PAIR: pair_w = coef_bank[0];
      csbf_pkg::REG_B1_PAIR: pair_w = coef_bank[1];
      csbf_pkg::REG_B2_PAIR: pair_w = coef_bank[2];
      csbf_pkg::REG_A1_PAIR: pair_w = coef_bank[3];
      csbf_pkg::REG_A2_PAIR: pair_w = coef_bank[4];
      default:               pair_w = '0;
    endcase
    if (ctrl.mul_stage == csbf_pkg::STAGE_HIGH) begin
      coef_w = pair_w[csbf_pkg::COEF_BITS-1:0];
    end else begin
      coef_w = pair_w[csbf_pkg::CFG_BITS-1:csbf_pkg::COEF_BITS];
    end
  end

  assign opnd_w   = (ctrl.opnd == csbf_pkg::OPND_IN) ? x_in : y_r;
  assign prod_nxt = coef_w * opnd_w;

  // align product to the state fraction, round half up, clamp
  always_comb begin
    wide_w    = WIDE_W'(prod_r);
    shifted_w = ((wide_w + TERM_HALF) >>> RSH) <<< LSH;
    if (shifted_w > TERM_MAX) begin
      term_w = TERM_W'(TERM_MAX);
    end else if (shifted_w < TERM_MIN) begin
      term_w = TERM_W'(TERM_MIN);
    end else begin
      term_w = TERM_W'(shifted_w);
    end
  end

  // stage output: round half up to sample fraction, saturate
  always_comb begin
    yr_w = (acc_a_r + Y_HALF) >>> OUT_SHIFT;
    if (yr_w > Y_MAX) begin
      y_sat_w = SAMPLE_BITS'(Y_MAX);
    end else if (yr_w < Y_MIN) begin
      y_sat_w = SAMPLE_BITS'(Y_MIN);
    end else begin
      y_sat_w = SAMPLE_BITS'(yr_w);
    end
  end

  assign d_sel_w = (ctrl.acc_op == csbf_pkg::ACC_A_T_D1) ? d1_r[ctrl.acc_stage]
                                                         : d2_r[ctrl.acc_stage];

  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    case (ctrl.acc_op)
      csbf_pkg::ACC_A_T_D1,
      csbf_pkg::ACC_A_T_D2: acc_a_nxt = ACC_W'(term_w) + ACC_W'(d_sel_w);
      csbf_pkg::ACC_B_T:    acc_b_nxt = ACC_W'(term_w);
      default: ;
    endcase
  end

  // delay update: partial sum minus feedback term, saturate to state range
  always_comb begin
    if (ctrl.acc_op == csbf_pkg::ACC_D1_WB) begin
      wb_w = acc_a_r - ACC_W'(term_w);
    end else begin
      wb_w = acc_b_r - ACC_W'(term_w);
    end
    if (wb_w > ST_MAX) begin
      wb_sat_w = csbf_pkg::STATE_BITS'(ST_MAX);
    end else if (wb_w < ST_MIN) begin
      wb_sat_w = csbf_pkg::STATE_BITS'(ST_MIN);
    end else begin
      wb_sat_w = csbf_pkg::STATE_BITS'(wb_w);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.y_ld) begin
      y_r <= y_sat_w;
    end
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r[0] <= '0;
      d1_r[1] <= '0;
      d2_r[0] <= '0;
      d2_r[1] <= '0;
    end else begin
      if (ctrl.acc_op == csbf_pkg::ACC_D1_WB) begin
        d1_r[ctrl.acc_stage] <= wb_sat_w;
      end
      if (ctrl.acc_op == csbf_pkg::ACC_D2_WB) begin
        d2_r[ctrl.acc_stage] <= wb_sat_w;
      end
    end
  end

  assign y_out = y_r;

endmodule

// ----- design/cascaded_shelf_biquad_filter_unit.sv -----
// Top level of the cascaded shelf biquad filter: coefficient registers,
// input latch, output register. Depends on csbf_pkg, csbf_sequencer, csbf_datapath.
//
// Each sample runs through a high shelf then a low shelf biquad (transposed
// direct form II). One sample is in flight at a time: a request is taken,
// then twelve microcode steps drive a single shared 32 x SAMPLE_BITS
// multiplier through ten products before the next request can be taken.
// The finished sample sits in an output register; the sequencer waits on
// it only if the previous result is still untaken. Coefficient writes take
// effect at once and belong in idle time. Delay state resets to zero,
// coefficients to unity gain.
module cascaded_shelf_biquad_filter_unit #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [csbf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [csbf_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_in,
  input  logic                                   in_last_of_block,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          out_sample_out,
  output logic                                   out_end_of_block
);

  logic [csbf_pkg::COEF_NUM-1:0][csbf_pkg::CFG_BITS-1:0] coef_r;
  logic signed [SAMPLE_BITS-1:0]                         x_in_r;
  logic                                                  last_r;
  logic                                                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0]                         out_sample_r;
  logic                                                  out_eob_r;
  logic signed [SAMPLE_BITS-1:0]                         y_w;
  logic                                                  out_free;
  logic                                                  out_load;
  logic                                                  in_take;
  csbf_pkg::ctrl_t                                       ctrl;

  assign out_free = !out_valid_r || out_ready;
  assign out_load = ctrl.out_ld && out_free;
  assign in_ready = in_take;

  csbf_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl),
    .in_take  (in_take)
  );

  csbf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .coef_bank (coef_r),
    .x_in      (x_in_r),
    .y_out     (y_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= csbf_pkg::COEF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        csbf_pkg::REG_B0_PAIR: coef_r[0] <= cfg_data;
        csbf_pkg::REG_B1_PAIR: coef_r[1] <= cfg_data;
        csbf_pkg::REG_B2_PAIR: coef_r[2] <= cfg_data;
        csbf_pkg::REG_A1_PAIR: coef_r[3] <= cfg_data;
        csbf_pkg::REG_A2_PAIR: coef_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_take) begin
      x_in_r <= in_sample_in;
      last_r <= in_last_of_block;
    end
    if (out_load) begin
      out_sample_r <= y_w;
      out_eob_r    <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_end_of_block = out_eob_r;

endmodule

// ----- design/csbf_checker.sv -----
// Port-level checker for the cascaded shelf biquad filter unit, with its bind.
// Depends on cascaded_shelf_biquad_filter_unit_macros.svh.
`include "cascaded_shelf_biquad_filter_unit_macros.svh"

module csbf_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_end_of_block
);

  // hold a stalled result
  `CSBF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out) && $stable(out_end_of_block), "stalled result changed")

  // drop ready while a request is being worked
  `CSBF_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready ##1 !in_ready, "new request taken too early")

  // advance to a result only from the busy phase
  `CSBF_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "result appeared while idle")

endmodule

bind cascaded_shelf_biquad_filter_unit csbf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_csbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_sample_out   (out_sample_out),
  .out_end_of_block (out_end_of_block)
);
